// ===== hdl/nss_pkg.sv =====
package nss_pkg;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 16;
  localparam int FRAC_W  = 16;
  localparam int FQ_W    = FRAC_W + 1;
  localparam int DIST_W  = 2 * COORD_W + 2;
  localparam int DIFF_W  = COORD_W + 1;       // v - q
  localparam int EDGE_W  = COORD_W + 2;       // v1 - v0
  localparam int MUL_W   = EDGE_W + 1;        // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W;            // dot product accumulator
  localparam int ESQ_W   = 2 * COORD_W + 4;   // |e|^2, also bound on d
  localparam int HALF_W  = ESQ_W / 2;
  localparam int SQ_W    = 2 * ESQ_W;         // d^2
  localparam int QUO_W   = ESQ_W;
  localparam int CNT_W   = $clog2(QUO_W);

  typedef enum logic [1:0] {
    GRP_DOT,
    GRP_ESQ,
    GRP_ASQ,
    GRP_BSQ
  } grp_e;

  typedef enum logic [1:0] {
    REG_QUERY_X,
    REG_QUERY_Y,
    REG_QUERY_Z
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic [INDEX_W-1:0]        segment_index;
    logic                      last_segment;
  } seg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] best_index;
    logic [FQ_W-1:0]    best_fraction;
    logic [DIST_W-1:0]  best_distance_sq;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    grp_e       grp;
    logic [1:0] comp;
    logic       sq_en;
    logic       div_load_frac;
    logic       div_load_corr;
    logic       div_step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic proj;
    logic last;
    logic out_stall;
  } sts_t;

endpackage

// ===== hdl/nss_dp.sv =====
module nss_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [nss_pkg::COORD_W-1:0] cfg_data_i,
  input  nss_pkg::seg_t    seg_i,
  input  nss_pkg::cmd_t    cmd_i,
  output nss_pkg::sts_t    sts_o,
  output nss_pkg::res_t    res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i
);
  import nss_pkg::*;

  logic signed [COORD_W-1:0] qx_q, qy_q, qz_q;
  logic signed [DIFF_W-1:0]  ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [DIFF_W-1:0]  ax_d, ay_d, az_d, bx_d, by_d, bz_d;
  logic signed [EDGE_W-1:0]  ex_q, ey_q, ez_q;
  logic [INDEX_W-1:0]        idx_q;
  logic                      last_q;

  logic signed [ACC_W-1:0]   dot_q;
  logic [ESQ_W-1:0]          esq_q;
  logic [DIST_W-1:0]         asq_q, bsq_q;
  logic [SQ_W-1:0]           sq_q;

  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc_base, acc_sum;

  logic signed [ACC_W-1:0]   d_val;
  logic [ESQ_W-1:0]          d_mag;
  logic [HALF_W-1:0]         d_lo, d_hi;
  logic                      proj;

  logic [ESQ_W-1:0]          rem_q, sh_q;
  logic [QUO_W-1:0]          quo_q;
  logic [FQ_W-1:0]           frac_q;
  logic [ESQ_W:0]            trial, trial_diff;
  logic                      trial_ge;

  logic [QUO_W:0]            corr, a_ext;
  logic [DIST_W-1:0]         cand_dist;
  logic [FQ_W-1:0]           frac;
  logic                      take;

  logic [DIST_W-1:0]         min_dist_q;
  logic [INDEX_W-1:0]        min_idx_q;
  logic [FQ_W-1:0]           min_frac_q;
  logic                      have_q;
  logic [DIST_W-1:0]         n_dist;
  logic [INDEX_W-1:0]        n_idx;
  logic [FQ_W-1:0]           n_frac;

  res_t                      res_q;
  logic                      res_valid_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
      qz_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_QUERY_X: qx_q <= cfg_data_i;
        REG_QUERY_Y: qy_q <= cfg_data_i;
        REG_QUERY_Z: qz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ax_d = DIFF_W'(seg_i.start_x) - DIFF_W'(qx_q);
  assign ay_d = DIFF_W'(seg_i.start_y) - DIFF_W'(qy_q);
  assign az_d = DIFF_W'(seg_i.start_z) - DIFF_W'(qz_q);
  assign bx_d = DIFF_W'(seg_i.end_x) - DIFF_W'(qx_q);
  assign by_d = DIFF_W'(seg_i.end_y) - DIFF_W'(qy_q);
  assign bz_d = DIFF_W'(seg_i.end_z) - DIFF_W'(qz_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      az_q   <= az_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      bz_q   <= bz_d;
      ex_q   <= EDGE_W'(bx_d) - EDGE_W'(ax_d);
      ey_q   <= EDGE_W'(by_d) - EDGE_W'(ay_d);
      ez_q   <= EDGE_W'(bz_d) - EDGE_W'(az_d);
      idx_q  <= seg_i.segment_index;
      last_q <= seg_i.last_segment;
    end
  end

  assign d_val = -dot_q;
  assign d_mag = d_val[ESQ_W-1:0];
  assign d_lo  = d_mag[HALF_W-1:0];
  assign d_hi  = d_mag[ESQ_W-1:HALF_W];
  assign proj  = (esq_q != '0) && !d_val[ACC_W-1] && (d_val <= ACC_W'(esq_q));

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (cmd_i.sq_en) begin
      case (cmd_i.comp)
        2'd0: begin
          op_a = MUL_W'(d_lo);
          op_b = MUL_W'(d_lo);
        end
        2'd1: begin
          op_a = MUL_W'(d_hi);
          op_b = MUL_W'(d_lo);
        end
        default: begin
          op_a = MUL_W'(d_hi);
          op_b = MUL_W'(d_hi);
        end
      endcase
    end else begin
      case (cmd_i.grp)
        GRP_DOT: begin
          case (cmd_i.comp)
            2'd0:    begin op_a = MUL_W'(ax_q); op_b = MUL_W'(ex_q); end
            2'd1:    begin op_a = MUL_W'(ay_q); op_b = MUL_W'(ey_q); end
            default: begin op_a = MUL_W'(az_q); op_b = MUL_W'(ez_q); end
          endcase
        end
        GRP_ESQ: begin
          case (cmd_i.comp)
            2'd0:    begin op_a = MUL_W'(ex_q); op_b = MUL_W'(ex_q); end
            2'd1:    begin op_a = MUL_W'(ey_q); op_b = MUL_W'(ey_q); end
            default: begin op_a = MUL_W'(ez_q); op_b = MUL_W'(ez_q); end
          endcase
        end
        GRP_ASQ: begin
          case (cmd_i.comp)
            2'd0:    begin op_a = MUL_W'(ax_q); op_b = MUL_W'(ax_q); end
            2'd1:    begin op_a = MUL_W'(ay_q); op_b = MUL_W'(ay_q); end
            default: begin op_a = MUL_W'(az_q); op_b = MUL_W'(az_q); end
          endcase
        end
        default: begin
          case (cmd_i.comp)
            2'd0:    begin op_a = MUL_W'(bx_q); op_b = MUL_W'(bx_q); end
            2'd1:    begin op_a = MUL_W'(by_q); op_b = MUL_W'(by_q); end
            default: begin op_a = MUL_W'(bz_q); op_b = MUL_W'(bz_q); end
          endcase
        end
      endcase
    end
  end

  assign prod = op_a * op_b;

  always_comb begin
    case (cmd_i.grp)
      GRP_DOT: acc_base = dot_q;
      GRP_ESQ: acc_base = ACC_W'(esq_q);
      GRP_ASQ: acc_base = ACC_W'(asq_q);
      default: acc_base = ACC_W'(bsq_q);
    endcase
    if (cmd_i.comp == 2'd0) begin
      acc_base = '0;
    end
    acc_sum = acc_base + ACC_W'(prod);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.grp)
        GRP_DOT: dot_q <= acc_sum;
        GRP_ESQ: esq_q <= acc_sum[ESQ_W-1:0];
        GRP_ASQ: asq_q <= acc_sum[DIST_W-1:0];
        default: bsq_q <= acc_sum[DIST_W-1:0];
      endcase
    end
    // d^2 from 18-bit halves: lo*lo + 2*hi*lo<<H + hi*hi<<2H
    if (cmd_i.sq_en) begin
      case (cmd_i.comp)
        2'd0:    sq_q <= SQ_W'(prod[ESQ_W-1:0]);
        2'd1:    sq_q <= sq_q + (SQ_W'(prod[ESQ_W-1:0]) << (HALF_W + 1));
        default: sq_q <= sq_q + (SQ_W'(prod[ESQ_W-1:0]) << ESQ_W);
      endcase
    end
  end

  // restoring divider, one quotient bit a cycle, divisor |e|^2
  assign trial      = {rem_q, sh_q[ESQ_W-1]};
  assign trial_ge   = trial >= {1'b0, esq_q};
  assign trial_diff = trial - {1'b0, esq_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load_frac) begin
      rem_q <= {1'b0, d_mag[ESQ_W-1:1]};
      sh_q  <= {d_mag[0], {(ESQ_W-1){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_load_corr) begin
      frac_q <= quo_q[FQ_W-1:0];
      rem_q  <= sq_q[SQ_W-1:ESQ_W];
      sh_q   <= sq_q[ESQ_W-1:0];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_diff[ESQ_W-1:0] : trial[ESQ_W-1:0];
      sh_q  <= {sh_q[ESQ_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], trial_ge};
    end
  end

  // candidate for this segment
  assign corr  = (QUO_W+1)'(quo_q) + (QUO_W+1)'(rem_q != '0);
  assign a_ext = (QUO_W+1)'(asq_q);

  always_comb begin
    if (proj) begin
      frac      = frac_q;
      cand_dist = (corr <= a_ext) ? DIST_W'(a_ext - corr) : '0;
    end else if (asq_q < bsq_q) begin
      frac      = '0;
      cand_dist = asq_q;
    end else begin
      frac      = FQ_W'(1) << FRAC_W;
      cand_dist = bsq_q;
    end
  end

  assign take   = !have_q || (cand_dist < min_dist_q);
  assign n_dist = take ? cand_dist : min_dist_q;
  assign n_idx  = take ? idx_q : min_idx_q;
  assign n_frac = take ? frac : min_frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q  <= '1;
      min_idx_q   <= '0;
      min_frac_q  <= '0;
      have_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish && last_q) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          min_dist_q  <= '1;
          min_idx_q   <= '0;
          min_frac_q  <= '0;
          have_q      <= 1'b0;
        end else begin
          min_dist_q <= n_dist;
          min_idx_q  <= n_idx;
          min_frac_q <= n_frac;
          have_q     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && last_q) begin
      res_q.best_index       <= n_idx;
      res_q.best_fraction    <= n_frac;
      res_q.best_distance_sq <= n_dist;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  assign sts_o.proj      = proj;
  assign sts_o.last      = last_q;
  assign sts_o.out_stall = res_valid_q && !res_ready_i;

endmodule

// ===== hdl/nss_ctrl.sv =====
module nss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          seg_valid_i,
  output logic          seg_ready_o,
  input  nss_pkg::sts_t sts_i,
  output nss_pkg::cmd_t cmd_o
);
  import nss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQ,
    ST_DIVF_LD,
    ST_DIVF,
    ST_DIVC_LD,
    ST_DIVC,
    ST_FIN
  } state_e;

  state_e            state_q;
  grp_e              grp_q;
  logic [1:0]        comp_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              fin_ok;

  assign fin_ok = !(sts_i.last && sts_i.out_stall);

  always_comb begin
    cmd_o               = '0;
    cmd_o.grp           = grp_q;
    cmd_o.comp          = comp_q;
    seg_ready_o         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        seg_ready_o = 1'b1;
        cmd_o.load  = seg_valid_i;
      end
      ST_MUL:     cmd_o.mul_en        = 1'b1;
      ST_SQ:      cmd_o.sq_en         = 1'b1;
      ST_DIVF_LD: cmd_o.div_load_frac = 1'b1;
      ST_DIVF:    cmd_o.div_step      = 1'b1;
      ST_DIVC_LD: cmd_o.div_load_corr = 1'b1;
      ST_DIVC:    cmd_o.div_step      = 1'b1;
      ST_FIN:     cmd_o.finish        = fin_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      grp_q   <= GRP_DOT;
      comp_q  <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          grp_q  <= GRP_DOT;
          comp_q <= '0;
          if (seg_valid_i) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (comp_q == 2'd2) begin
            comp_q <= '0;
            if (grp_q == GRP_BSQ) begin
              state_q <= sts_i.proj ? ST_SQ : ST_FIN;
            end else begin
              grp_q <= grp_e'(grp_q + 2'd1);
            end
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        ST_SQ: begin
          if (comp_q == 2'd2) begin
            comp_q  <= '0;
            state_q <= ST_DIVF_LD;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        ST_DIVF_LD: begin
          cnt_q   <= '0;
          state_q <= ST_DIVF;
        end
        ST_DIVF: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(FQ_W - 1)) begin
            state_q <= ST_DIVC_LD;
          end
        end
        ST_DIVC_LD: begin
          cnt_q   <= '0;
          state_q <= ST_DIVC;
        end
        ST_DIVC: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(QUO_W - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_ok) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/nearest_segment_search_unit.sv =====
// Nearest segment search.
// Write the query point through the config channel (index 0..2 = x, y, z;
// other indexes are dropped). cfg_ready_o is always high.
// Segments then arrive on seg_*; one request is taken per idle slot. Each
// segment is reduced to a candidate (index, fraction, squared distance) and
// folded into a running minimum; earlier segments win on equal distance.
// A segment with last_segment set produces one result on res_* and clears
// the running minimum for the next search.
// Work per segment, done on the single shared 19x19 multiplier and the
// radix-2 divider on |e|^2, in this order:
//   endpoint case:   accept, multiply (dot, |e|^2, |a|^2, |b|^2), finish
//   projection case: adds the multiply for d^2, then the fraction divider
//                    load and bits, the correction load and bits, before finish
// The result is valid the cycle after finish and sits in an output register;
// a new segment is accepted while it waits. Only a following last segment
// stalls in its final cycle until the receiver takes the pending result.
// Reset clears the query point to zero, the running minimum and res_valid_o.
module nearest_segment_search_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [nss_pkg::COORD_W-1:0] cfg_data_i,
  input  logic                        seg_valid_i,
  output logic                        seg_ready_o,
  input  nss_pkg::seg_t               seg_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output nss_pkg::res_t               res_o
);
  import nss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  nss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_valid_i (seg_valid_i),
    .seg_ready_o (seg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .seg_i       (seg_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i)
  );

endmodule
